// File: hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, request codes, character codes and the control and status
// bundles of the shared remainder unit.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Field widths of the request and response channels
	localparam int REQ_W  = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;

	typedef logic [REQ_W-1:0]  req_kind_t;
	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [IDX_W-1:0]  cell_idx_t;

	// Request codes
	localparam req_kind_t REQ_PUT   = 2'd0;
	localparam req_kind_t REQ_READ  = 2'd1;
	localparam req_kind_t REQ_CLEAR = 2'd2;

	// Character codes with a meaning of their own
	localparam char_t CHAR_NUL   = 8'h00;
	localparam char_t CHAR_TAB   = 8'h09;
	localparam char_t CHAR_NL    = 8'h0A;
	localparam char_t CHAR_SPACE = 8'h20;

	// Remainder unit control: start a run, pick tab stop or row width
	typedef struct packed {
		logic start;
		logic use_tab;
	} rem_ctl_t;

	// Remainder unit status
	typedef struct packed {
		logic busy;
		logic done;
	} rem_sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/tcw_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console request channel
// Valid/ready channel carrying one put, read or clear request.
// ----------------------------------------------------------------------------
interface tcw_in_if;
	logic                valid;
	logic                ready;
	tcw_pkg::req_kind_t  req_type;
	tcw_pkg::char_t      char_code;
	logic                end_of_string;
	tcw_pkg::cell_idx_t  cell_index;

	modport source (
		output valid, req_type, char_code, end_of_string, cell_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, char_code, end_of_string, cell_index,
		output ready
	);
endinterface
`default_nettype wire

// File: hw/rtl/tcw_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Console response channel
// Valid/ready channel carrying the cursor and read data of one request.
// ----------------------------------------------------------------------------
interface tcw_out_if;
	logic                valid;
	logic                ready;
	tcw_pkg::cell_idx_t  cursor_position;
	logic                cursor_update;
	tcw_pkg::char_t      cell_char;

	modport source (
		output valid, cursor_position, cursor_update, cell_char,
		input  ready
	);
	modport sink (
		input  valid, cursor_position, cursor_update, cell_char,
		output ready
	);
endinterface
`default_nettype wire

// File: hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/tcw_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared remainder unit
// Remainder of the cursor by the row width or the tab stop, by reciprocal
// multiplication: the quotient is registered first, then the remainder.
// ----------------------------------------------------------------------------
module tcw_rem #(
	parameter int DIV_W = 12,
	parameter int REM_W = 8,
	parameter int MOD_A = 80,
	parameter int MOD_B = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tcw_pkg::rem_ctl_t ctl,
	input  wire logic [DIV_W-1:0]  dividend,
	output tcw_pkg::rem_sts_t      sts,
	output logic      [REM_W-1:0]  rem
);

	// Reciprocals rounded up; the shift covers every dividend of DIV_W bits
	localparam int     SH     = DIV_W + REM_W;
	localparam int     PROD_W = DIV_W + SH;
	localparam int     BACK_W = DIV_W + REM_W;
	localparam longint RCP_A  = ((longint'(1) <<< SH) + longint'(MOD_A) - 1) / longint'(MOD_A);
	localparam longint RCP_B  = ((longint'(1) <<< SH) + longint'(MOD_B) - 1) / longint'(MOD_B);

	logic              busy_q;
	logic              done_q;
	logic              phase_q;
	logic [DIV_W-1:0]  num_q;
	logic [REM_W-1:0]  mod_q;
	logic [SH-1:0]     rcp_q;
	logic [DIV_W-1:0]  quo_q;
	logic [REM_W-1:0]  rem_q;
	logic [PROD_W-1:0] prod;
	logic [BACK_W-1:0] back;
	logic [BACK_W-1:0] diff;

	// Quotient: dividend times reciprocal, drop the fraction bits
	assign prod = {{SH{1'b0}}, num_q} * {{DIV_W{1'b0}}, rcp_q};
	// Remainder: dividend less quotient times modulus
	assign back = {{REM_W{1'b0}}, quo_q} * {{DIV_W{1'b0}}, mod_q};
	assign diff = {{REM_W{1'b0}}, num_q} - back;

	// Run the two steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			num_q   <= '0;
			mod_q   <= '0;
			rcp_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				num_q   <= dividend;
				mod_q   <= ctl.use_tab ? REM_W'(MOD_B) : REM_W'(MOD_A);
				rcp_q   <= ctl.use_tab ? SH'(RCP_B) : SH'(RCP_A);
			end else if (busy_q) begin
				if (!phase_q) begin
					quo_q   <= prod[PROD_W-1:SH];
					phase_q <= 1'b1;
				end else begin
					rem_q  <= diff[REM_W-1:0];
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign rem      = rem_q;

endmodule
`default_nettype wire

// File: hw/rtl/text_console_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a plain character is written and the cursor checked in ST_CHECK; a read
//   fetches its cell in ST_READ; newline and tab first run the remainder unit in ST_DIV.
// A scroll sweeps all SCREEN_WIDTH * SCREEN_HEIGHT cells, and so does a clear;
//   one RAM write port serves both sweeps. ST_FIN then loads the output register.
// Requests are taken one at a time: ready is high only while the sequencer is idle.
// Reset: sequencer, cursor and output valid clear at once; screen RAM unknown until written.
// ----------------------------------------------------------------------------
// Text console writer core
// Character screen with cursor: put, read and clear requests, scroll on
// reaching the end of the screen, all through one RAM and one remainder unit.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25,
	parameter int TAB_STOP      = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tcw_in_if.sink     req,
	tcw_out_if.source  rsp
);

	localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int LAST_ROW   = SCREEN_WIDTH * (SCREEN_HEIGHT - 1);
	localparam int MOD_MAX    = (SCREEN_WIDTH > TAB_STOP) ? SCREEN_WIDTH : TAB_STOP;
	localparam int REM_W      = $clog2(MOD_MAX) + 1;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int CUR_W      = $clog2(CELL_COUNT + MOD_MAX + 1);
	localparam int IDX_W      = tcw_pkg::IDX_W;
	localparam int CHAR_W     = tcw_pkg::CHAR_W;

	// Sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_CLEAR  = 3'd4;
	localparam logic [2:0] ST_READ   = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0]        state_q;
	logic [CUR_W-1:0]  cur_q;
	logic [AW-1:0]     k_q;
	logic              tab_q;
	logic              upd_q;
	tcw_pkg::char_t    chr_q;

	// Write stage: every RAM write goes through here
	logic              wr_en_s1;
	logic [AW-1:0]     wr_addr_s1;
	logic              wr_copy_s1;
	tcw_pkg::char_t    wr_fill_s1;

	// Output register
	logic              ovalid_q;
	logic [IDX_W-1:0]  opos_q;
	logic              oupd_q;
	tcw_pkg::char_t    ochr_q;

	logic              accept;
	logic              fin_load;
	logic              code_nl;
	logic              code_tab;
	logic              idx_in_range;
	logic [AW+IDX_W-1:0]    idx_ext;
	logic [CUR_W+IDX_W-1:0] pos_ext;
	logic [AW-1:0]     rd_addr;
	logic [CHAR_W-1:0] rd_data;
	logic [CHAR_W-1:0] wr_data;
	logic [CUR_W-1:0]  step_mod;
	tcw_pkg::rem_ctl_t rem_ctl;
	tcw_pkg::rem_sts_t rem_sts;
	logic [REM_W-1:0]  rem;

	// Decode the request
	assign req.ready    = (state_q == ST_IDLE);
	assign accept       = req.valid && req.ready;
	assign code_nl      = (req.char_code == tcw_pkg::CHAR_NL);
	assign code_tab     = (req.char_code == tcw_pkg::CHAR_TAB);
	assign idx_in_range = (32'(req.cell_index) < 32'(CELL_COUNT));
	assign idx_ext      = {{AW{1'b0}}, req.cell_index};
	assign pos_ext      = {{IDX_W{1'b0}}, cur_q};
	assign fin_load     = (state_q == ST_FIN) && (!ovalid_q || rsp.ready);

	// Start the remainder unit for newline and tab
	assign rem_ctl.start   = accept && (req.req_type == tcw_pkg::REQ_PUT)
	                         && (code_nl || code_tab);
	assign rem_ctl.use_tab = code_tab;

	assign step_mod = tab_q ? CUR_W'(TAB_STOP) : CUR_W'(SCREEN_WIDTH);

	// Read one row below during a scroll, else the requested cell
	assign rd_addr = (state_q == ST_SCROLL) ? (k_q + AW'(SCREEN_WIDTH)) : idx_ext[AW-1:0];
	assign wr_data = wr_copy_s1 ? rd_data : wr_fill_s1;

	tcw_rem #(
		.DIV_W (CUR_W),
		.REM_W (REM_W),
		.MOD_A (SCREEN_WIDTH),
		.MOD_B (TAB_STOP)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rem_ctl),
		.dividend (cur_q),
		.sts      (rem_sts),
		.rem      (rem)
	);

	tcw_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (wr_en_s1),
		.waddr (wr_addr_s1),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Sequence one request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cur_q      <= '0;
			k_q        <= '0;
			tab_q      <= 1'b0;
			upd_q      <= 1'b0;
			chr_q      <= '0;
			wr_en_s1   <= 1'b0;
			wr_addr_s1 <= '0;
			wr_copy_s1 <= 1'b0;
			wr_fill_s1 <= '0;
		end else begin
			wr_en_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						chr_q <= '0;
						case (req.req_type)
							tcw_pkg::REQ_PUT: begin
								upd_q <= req.end_of_string;
								if (req.char_code == tcw_pkg::CHAR_NUL) begin
									state_q <= ST_FIN;
								end else if (code_nl || code_tab) begin
									tab_q   <= code_tab;
									state_q <= ST_DIV;
								end else begin
									wr_en_s1   <= 1'b1;
									wr_addr_s1 <= cur_q[AW-1:0];
									wr_copy_s1 <= 1'b0;
									wr_fill_s1 <= req.char_code;
									cur_q      <= cur_q + CUR_W'(1);
									state_q    <= ST_CHECK;
								end
							end
							tcw_pkg::REQ_READ: begin
								upd_q   <= 1'b0;
								state_q <= idx_in_range ? ST_READ : ST_FIN;
							end
							tcw_pkg::REQ_CLEAR: begin
								upd_q   <= 1'b1;
								k_q     <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
								upd_q   <= 1'b0;
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_DIV: begin
					// Advance to the next row start or tab stop
					if (rem_sts.done) begin
						cur_q   <= cur_q + step_mod - CUR_W'(rem);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (cur_q >= CUR_W'(CELL_COUNT)) begin
						k_q     <= '0;
						state_q <= ST_SCROLL;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SCROLL: begin
					// Copy each cell from one row below, then blank the last row
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= k_q;
					wr_copy_s1 <= (k_q < AW'(LAST_ROW));
					wr_fill_s1 <= tcw_pkg::CHAR_NUL;
					if (k_q == AW'(CELL_COUNT - 1)) begin
						cur_q   <= CUR_W'(LAST_ROW);
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				ST_CLEAR: begin
					wr_en_s1   <= 1'b1;
					wr_addr_s1 <= k_q;
					wr_copy_s1 <= 1'b0;
					wr_fill_s1 <= tcw_pkg::CHAR_SPACE;
					if (k_q == AW'(CELL_COUNT - 1)) begin
						cur_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						k_q <= k_q + AW'(1);
					end
				end
				ST_READ: begin
					chr_q   <= rd_data;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			opos_q   <= '0;
			oupd_q   <= 1'b0;
			ochr_q   <= '0;
		end else begin
			if (fin_load) begin
				ovalid_q <= 1'b1;
				opos_q   <= pos_ext[IDX_W-1:0];
				oupd_q   <= upd_q;
				ochr_q   <= chr_q;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = ovalid_q;
	assign rsp.cursor_position = opos_q;
	assign rsp.cursor_update   = oupd_q;
	assign rsp.cell_char       = ochr_q;

	// Cursor stays on the screen between requests
	a_cur_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cur_q < CUR_W'(CELL_COUNT)))
		else $error("cursor beyond screen while idle");

	// Writes never leave the screen
	a_wr_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s1 |-> (32'(wr_addr_s1) < 32'(CELL_COUNT)))
		else $error("screen write out of range");

	// No request is taken while the remainder unit runs
	a_rem_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rem_sts.busy)
		else $error("request taken with remainder unit busy");

	// A scroll leaves the cursor at the start of the last row
	a_scroll_home: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCROLL) && (k_q == AW'(CELL_COUNT - 1)))
		|=> (cur_q == CUR_W'(LAST_ROW)))
		else $error("cursor not on last row after scroll");

endmodule
`default_nettype wire

// File: tb/tcw_console_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer response checker
// Watches both channels and keeps its own copy of the screen and the cursor.
// Each accepted request updates that copy and queues the response it should
// give. Each accepted response is compared field by field with the oldest
// queued one. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module tcw_console_checker #(
	parameter int SCREEN_WIDTH  = 80,
	parameter int SCREEN_HEIGHT = 25,
	parameter int TAB_STOP      = 8
) (
	input  logic clk,
	input  logic arst_n,
	tcw_in_if    req,
	tcw_out_if   rsp,
	output int   mismatch_count,
	output int   responses_owed
);

	localparam int CELLS      = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int LAST_ROW   = SCREEN_WIDTH * (SCREEN_HEIGHT - 1);

	typedef struct packed {
		tcw_pkg::cell_idx_t cursor;
		logic               cursor_write;
		tcw_pkg::char_t     cell_code;
	} console_rsp_t;

	tcw_pkg::char_t screen_copy [CELLS];
	int unsigned    cursor_at = 0;
	console_rsp_t   awaited_rsps [$];
	int             mismatches = 0;
	int             owed = 0;

	assign mismatch_count = mismatches;
	assign responses_owed = owed;

	initial begin
		foreach (screen_copy[k]) screen_copy[k] = tcw_pkg::CHAR_NUL;
	end

	// Print one line for a mismatch and count it
	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Apply one request to the screen copy and work out its response
	function automatic console_rsp_t console_response(tcw_pkg::req_kind_t kind,
			tcw_pkg::char_t code, logic eos, tcw_pkg::cell_idx_t idx);
		console_rsp_t r;
		r = '0;
		case (kind)
			tcw_pkg::REQ_PUT: begin
				if (code == tcw_pkg::CHAR_NL) begin
					cursor_at += SCREEN_WIDTH - cursor_at % SCREEN_WIDTH;
				end else if (code == tcw_pkg::CHAR_TAB) begin
					cursor_at += TAB_STOP - cursor_at % TAB_STOP;
				end else if (code != tcw_pkg::CHAR_NUL) begin
					screen_copy[cursor_at] = code;
					cursor_at++;
				end
				// Scroll: move every row up one, blank the last with zero codes
				if (cursor_at >= CELLS) begin
					for (int k = 0; k < LAST_ROW; k++)
						screen_copy[k] = screen_copy[k + SCREEN_WIDTH];
					for (int k = LAST_ROW; k < CELLS; k++)
						screen_copy[k] = tcw_pkg::CHAR_NUL;
					cursor_at = LAST_ROW;
				end
				r.cursor_write = eos;
			end
			tcw_pkg::REQ_READ: begin
				if (idx < CELLS) r.cell_code = screen_copy[idx];
			end
			tcw_pkg::REQ_CLEAR: begin
				foreach (screen_copy[k]) screen_copy[k] = tcw_pkg::CHAR_SPACE;
				cursor_at = 0;
				r.cursor_write = 1'b1;
			end
			default: begin
			end
		endcase
		r.cursor = tcw_pkg::cell_idx_t'(cursor_at);
		return r;
	endfunction

	// Predict on each accepted request, compare each accepted response
	always @(posedge clk or negedge arst_n) begin : watch
		console_rsp_t want;
		if (!arst_n) begin
			cursor_at = 0;
			awaited_rsps.delete();
		end else begin
			if (req.valid === 1'b1 && req.ready === 1'b1)
				awaited_rsps.push_back(console_response(req.req_type, req.char_code,
					req.end_of_string, req.cell_index));
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (awaited_rsps.size() == 0) begin
					flag_mismatch("response with no request", rsp.cursor_position, 0);
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp.cursor_position !== want.cursor)
						flag_mismatch("cursor_position", rsp.cursor_position, want.cursor);
					if (rsp.cursor_update !== want.cursor_write)
						flag_mismatch("cursor_update", rsp.cursor_update, want.cursor_write);
					if (rsp.cell_char !== want.cell_code)
						flag_mismatch("cell_char", rsp.cell_char, want.cell_code);
				end
			end
		end
		owed = awaited_rsps.size();
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Clears the screen, runs a short directed set of puts, reads, tabs, newlines,
// terminators and unknown requests, then random strings, reads and noise in
// four phases of sender idling and receiver stalling. The checker beside the
// core predicts every response; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

	localparam int                 SCREEN_WIDTH  = 80;
	localparam int                 SCREEN_HEIGHT = 25;
	localparam int                 TAB_STOP      = 8;
	localparam int                 CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int                 RANDOM_ITEMS  = 1650;
	localparam int                 PHASES        = 4;
	// Longer than one scroll or clear sweep of the screen memory
	localparam int                 DRAIN_CYCLES  = CELLS + 200;
	// Every request scrolling, with stalls on both sides, several times over
	localparam longint             TIMEOUT_NS    = 250_000_000;
	localparam tcw_pkg::req_kind_t REQ_UNKNOWN   = 2'd3;
	localparam tcw_pkg::char_t     CHAR_DEL      = 8'h7F;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	int   idle_pct  = 0;
	int   stall_pct = 0;
	int   sent      = 0;
	int   mismatch_count;
	int   responses_owed;
	int   idle_of  [PHASES] = '{0, 59, 0, 34};
	int   stall_of [PHASES] = '{0, 0, 59, 34};

	tcw_in_if  req_ch ();
	tcw_out_if rsp_ch ();

	text_console_writer_core #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TAB_STOP      (TAB_STOP)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tcw_console_checker #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.TAB_STOP      (TAB_STOP)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.mismatch_count (mismatch_count),
		.responses_owed (responses_owed)
	);

	always #6 clk = ~clk;

	// Stall the response channel at the current rate
	always @(posedge clk) begin
		rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	// Idle at random, then present one request until it is taken
	task automatic send_request(tcw_pkg::req_kind_t kind, tcw_pkg::char_t code, logic eos,
			tcw_pkg::cell_idx_t idx);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= kind;
		req_ch.char_code     <= code;
		req_ch.end_of_string <= eos;
		req_ch.cell_index    <= idx;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent++;
	endtask

	// Hold off until every response owed has come back
	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (responses_owed != 0);
		@(posedge clk);
	endtask

	// One string of mostly printable characters, flagged on its last one
	task automatic send_string();
		int             len;
		int             pick;
		tcw_pkg::char_t c;
		len = $urandom_range(24, 1);
		for (int n = 0; n < len; n++) begin
			pick = $urandom_range(99);
			if (pick < 10)
				c = tcw_pkg::CHAR_NL;
			else if (pick < 16)
				c = tcw_pkg::CHAR_TAB;
			else if (pick < 20)
				c = tcw_pkg::char_t'($urandom_range(255, 1));
			else
				c = tcw_pkg::char_t'($urandom_range(8'h7E, 8'h20));
			send_request(tcw_pkg::REQ_PUT, c, n == len - 1,
				tcw_pkg::cell_idx_t'($urandom_range(2047)));
		end
	endtask

	initial begin
		int target;
		int pick;
		req_ch.valid         = 1'b0;
		req_ch.req_type      = tcw_pkg::REQ_PUT;
		req_ch.char_code     = tcw_pkg::CHAR_NUL;
		req_ch.end_of_string = 1'b0;
		req_ch.cell_index    = '0;
		rsp_ch.ready         = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Clear first so that every later read hits a written cell
		send_request(tcw_pkg::REQ_CLEAR, 8'hFF, 1'b0, 11'h7FF);
		send_request(tcw_pkg::REQ_READ, tcw_pkg::CHAR_NUL, 1'b1, 11'd0);
		send_request(tcw_pkg::REQ_READ, 8'hFF, 1'b0, 11'(CELLS - 1));
		send_request(tcw_pkg::REQ_READ, 8'hAA, 1'b0, 11'(CELLS));
		send_request(tcw_pkg::REQ_READ, 8'h55, 1'b1, 11'h7FF);
		send_request(tcw_pkg::REQ_PUT, 8'h41, 1'b0, 11'h7FF);
		send_request(tcw_pkg::REQ_PUT, 8'hFF, 1'b0, 11'd0);
		send_request(tcw_pkg::REQ_PUT, 8'h01, 1'b1, 11'd0);
		// Terminators: nothing moves, the cursor write follows the flag
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NUL, 1'b1, 11'd5);
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NUL, 1'b0, 11'd5);
		// Tab off a stop, tab from a stop, newline mid-row
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_TAB, 1'b0, 11'd0);
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_TAB, 1'b0, 11'd0);
		send_request(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NL, 1'b0, 11'd0);
		send_request(tcw_pkg::REQ_PUT, CHAR_DEL, 1'b1, 11'd0);
		send_request(tcw_pkg::REQ_READ, tcw_pkg::CHAR_NUL, 1'b0, 11'd0);
		send_request(tcw_pkg::REQ_READ, tcw_pkg::CHAR_NUL, 1'b0, 11'd2);
		send_request(tcw_pkg::REQ_READ, tcw_pkg::CHAR_NUL, 1'b0, 11'(SCREEN_WIDTH));
		send_request(REQ_UNKNOWN, tcw_pkg::char_t'($urandom_range(255)), 1'b1,
			tcw_pkg::cell_idx_t'($urandom_range(2047)));
		send_request(tcw_pkg::REQ_PUT, 8'h80, 1'b0, 11'h400);
		send_request(tcw_pkg::REQ_CLEAR, 8'h33, 1'b1, 11'd17);
		send_request(tcw_pkg::REQ_READ, tcw_pkg::CHAR_NUL, 1'b0, 11'd5);
		hold_until_drained();

		// Random phases: strings mostly, with reads, noise, clears and unknowns
		for (int p = 0; p < PHASES; p++) begin
			idle_pct  = idle_of[p];
			stall_pct = stall_of[p];
			target    = sent + RANDOM_ITEMS / PHASES;
			while (sent < target) begin
				pick = $urandom_range(99);
				if (pick < 60)
					send_string();
				else if (pick < 85)
					send_request(tcw_pkg::REQ_READ, tcw_pkg::char_t'($urandom_range(255)),
						1'($urandom_range(1)), tcw_pkg::cell_idx_t'($urandom_range(2047)));
				else if (pick < 95)
					send_request(tcw_pkg::REQ_PUT, tcw_pkg::char_t'($urandom_range(255)),
						1'($urandom_range(1)), tcw_pkg::cell_idx_t'($urandom_range(2047)));
				else if (pick < 96)
					send_request(tcw_pkg::REQ_CLEAR, tcw_pkg::char_t'($urandom_range(255)),
						1'($urandom_range(1)), tcw_pkg::cell_idx_t'($urandom_range(2047)));
				else if (pick < 98)
					send_request(REQ_UNKNOWN, tcw_pkg::char_t'($urandom_range(255)),
						1'($urandom_range(1)), tcw_pkg::cell_idx_t'($urandom_range(2047)));
				else
					send_request(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NUL, 1'($urandom_range(1)),
						tcw_pkg::cell_idx_t'($urandom_range(2047)));
			end
			hold_until_drained();
		end

		// Let any sweep in progress finish before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
